// ===== rtl/binding_point_allocator_macros.svh =====
// Assertion macros used by the port-level checker of the binding point allocator.
`ifndef BINDING_POINT_ALLOCATOR_MACROS_SVH
`define BINDING_POINT_ALLOCATOR_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define BPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that a stalled beat stays valid and keeps its payload.
`define BPA_HOLD(label, vld, stl, data) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && stl) |=> (vld && $stable(data))) \
        else $error("stalled beat was dropped or changed");

`endif

// ===== rtl/bpa_pkg.sv =====
// Types, constants and helper functions of the binding point allocator.
`default_nettype none
package bpa_pkg;

    localparam int unsigned CFG_BITS   = 6;
    localparam int unsigned POINT_BITS = 5;
    localparam int unsigned MASK_BITS  = 32;
    localparam int unsigned IKEY_BITS  = 32;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_MAX_FIRST  = 2'd0;
    localparam logic [1:0] CFG_MAX_SECOND = 2'd1;

    localparam logic [CFG_BITS-1:0] CFG_RESET_MAX = 6'd32;

    // Item kinds.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic                 block_type;
        logic [IKEY_BITS-1:0] buffer_key;
        logic [MASK_BITS-1:0] avoid_mask;
    } req_item_t;

    typedef struct packed {
        logic [POINT_BITS-1:0] point;
        logic                  no_point;
        logic                  table_full;
    } rsp_item_t;

    // Head of the queue between the front and the back.
    typedef struct packed {
        logic      valid;
        req_item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] max_first;
        logic [CFG_BITS-1:0] max_second;
    } cfg_regs_t;

    // Points at 32 and above cannot be forbidden by the mask.
    function automatic logic avoided_f(logic [MASK_BITS-1:0] mask, logic [5:0] p);
        logic res;
        res = (p < 6'd32) && mask[p[4:0]];
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bpa_ram.sv =====
// Generic single write port RAM with one registered read port.
`default_nettype none
module bpa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/bpa_front.sv =====
// Input side: accepts request beats into a two-entry queue for the back end.
`default_nettype none
module bpa_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire bpa_pkg::req_item_t  req,
    output bpa_pkg::queue_head_t     head,
    input  wire logic                pop
);
    import bpa_pkg::*;

    req_item_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       take;

    assign req_stall  = (cnt_reg == 2'd2);
    assign push       = req_valid && !req_stall;
    assign take       = pop && (cnt_reg != 2'd0);
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= req;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bpa_back.sv =====
// Execution side: table lookup, fresh or least-used point choice and bookkeeping.
`default_nettype none
module bpa_back #(
    parameter int unsigned MAX_POINTS    = 32,
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned KEY_BITS      = 32,
    parameter int unsigned COUNT_BITS    = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bpa_pkg::cfg_regs_t   cfg,
    input  wire bpa_pkg::queue_head_t head,
    output logic                      pop,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output bpa_pkg::rsp_item_t        rsp
);
    import bpa_pkg::*;

    localparam int unsigned PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned LW    = $clog2(MAX_POINTS + 1);
    localparam int unsigned EW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned FW    = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned CAW   = PW + 1;
    localparam int unsigned CDEP  = 2 << PW;
    localparam int unsigned EDW   = KEY_BITS + PW;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOKUP, S_HITCHK, S_FRESH, S_MINSCAN, S_STEP, S_INC, S_REC, S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic                  t_reg, t_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [MASK_BITS-1:0]  mask_reg, mask_next;
    logic [LW-1:0]         lim_reg, lim_next;
    logic [EW-1:0]         idx_reg, idx_next;
    logic                  hit_reg, hit_next;
    logic [EW-1:0]         hidx_reg, hidx_next;
    logic [PW-1:0]         hp_reg, hp_next;
    logic [PW-1:0]         p_reg, p_next;
    logic [PW-1:0]         c_reg, c_next;
    logic [COUNT_BITS-1:0] best_reg, best_next;
    logic                  rec_reg, rec_next;
    logic                  full_reg, full_next;
    logic                  nopt_reg, nopt_next;
    logic [LW-1:0]         fresh_reg [2];
    logic [LW-1:0]         fresh_next [2];
    logic [FW-1:0]         fill_reg, fill_next;
    logic [CDEP-1:0]       cvld_reg, cvld_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_item_t             rsp_reg, rsp_next;

    logic [CAW-1:0]        c_raddr, c_waddr;
    logic                  c_we;
    logic [COUNT_BITS-1:0] c_wdata, c_rdata, cval;
    logic [EW-1:0]         e_waddr;
    logic                  e_we;
    logic [EDW-1:0]        e_wdata, e_rdata;
    logic [CFG_BITS-1:0]   cfg_sel;
    logic [63:0]           low_mask;
    logic                  any_free;
    logic [LW-1:0]         fresh_cur;
    logic [KEY_BITS-1:0]   in_key;

    // Use counts of both types, one row per (type, point).
    bpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(CDEP)) u_count_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // Id table: key and point of each recorded buffer.
    bpa_ram #(.WIDTH(EDW), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (idx_next),
        .rdata (e_rdata)
    );

    assign c_raddr   = {t_next, c_next};
    assign c_waddr   = {t_reg, c_reg};
    assign cval      = cvld_reg[{t_reg, c_reg}] ? c_rdata : '0;
    assign low_mask  = (64'd1 << lim_reg) - 64'd1;
    assign any_free  = |({32'hFFFF_FFFF, ~mask_reg} & low_mask);
    assign fresh_cur = fresh_reg[t_reg];
    assign in_key    = KEY_BITS'(head.item.buffer_key);
    assign cfg_sel   = head.item.block_type ? cfg.max_second : cfg.max_first;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        key_next       = key_reg;
        mask_next      = mask_reg;
        lim_next       = lim_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        hidx_next      = hidx_reg;
        hp_next        = hp_reg;
        p_next         = p_reg;
        c_next         = c_reg;
        best_next      = best_reg;
        rec_next       = rec_reg;
        full_next      = full_reg;
        nopt_next      = nopt_reg;
        fresh_next     = fresh_reg;
        fill_next      = fill_reg;
        cvld_next      = cvld_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        pop            = 1'b0;
        c_we           = 1'b0;
        c_wdata        = (cval == {COUNT_BITS{1'b1}}) ? cval : cval + COUNT_BITS'(1);
        e_we           = 1'b0;
        e_waddr        = hidx_reg;
        e_wdata        = {key_reg, p_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.kind == KIND_CLEAR)
                    begin
                        fresh_next[0] = '0;
                        fresh_next[1] = '0;
                        fill_next     = '0;
                        cvld_next     = '0;
                    end
                    else
                    begin
                        t_next    = head.item.block_type;
                        key_next  = in_key;
                        mask_next = head.item.avoid_mask;
                        lim_next  = ({1'b0, cfg_sel} > 7'(MAX_POINTS)) ?
                                    LW'(MAX_POINTS) : LW'(cfg_sel);
                        hit_next  = 1'b0;
                        full_next = 1'b0;
                        nopt_next = 1'b0;
                        rec_next  = 1'b0;
                        idx_next  = '0;
                        if ((in_key != '0) && (fill_reg != '0))
                        begin
                            state_next = S_LOOKUP;
                        end
                        else
                        begin
                            state_next = S_FRESH;
                        end
                    end
                end
            end
            S_LOOKUP:
            begin
                if (e_rdata[EDW-1 -: KEY_BITS] == key_reg)
                begin
                    hit_next   = 1'b1;
                    hidx_next  = idx_reg;
                    hp_next    = e_rdata[PW-1:0];
                    state_next = S_HITCHK;
                end
                else if ((FW'(idx_reg) + FW'(1)) == fill_reg)
                begin
                    state_next = S_FRESH;
                end
                else
                begin
                    idx_next = idx_reg + EW'(1);
                end
            end
            S_HITCHK:
            begin
                if ((LW'(hp_reg) < lim_reg) && !avoided_f(mask_reg, 6'(hp_reg)))
                begin
                    p_next     = hp_reg;
                    c_next     = hp_reg;
                    rec_next   = 1'b0;
                    state_next = S_INC;
                end
                else
                begin
                    state_next = S_FRESH;
                end
            end
            S_FRESH:
            begin
                rec_next = (key_reg != '0);
                if ((fresh_cur < lim_reg) && !avoided_f(mask_reg, 6'(fresh_cur)))
                begin
                    p_next            = PW'(fresh_cur);
                    c_next            = PW'(fresh_cur);
                    fresh_next[t_reg] = fresh_cur + LW'(1);
                    state_next        = S_INC;
                end
                else if (!any_free)
                begin
                    nopt_next  = 1'b1;
                    rec_next   = 1'b0;
                    p_next     = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    c_next     = '0;
                    state_next = S_MINSCAN;
                end
            end
            S_MINSCAN:
            begin
                if ((c_reg == '0) || (cval < best_reg))
                begin
                    best_next = cval;
                    p_next    = c_reg;
                end
                if ((LW'(c_reg) + LW'(1)) == lim_reg)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    c_next = c_reg + PW'(1);
                end
            end
            S_STEP:
            begin
                if (avoided_f(mask_reg, 6'(p_reg)))
                begin
                    p_next = ((LW'(p_reg) + LW'(1)) >= lim_reg) ? '0 : p_reg + PW'(1);
                end
                else
                begin
                    c_next     = p_reg;
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                c_we                      = 1'b1;
                cvld_next[{t_reg, c_reg}] = 1'b1;
                state_next                = rec_reg ? S_REC : S_OUT;
            end
            S_REC:
            begin
                if (hit_reg)
                begin
                    e_we = 1'b1;
                end
                else if (fill_reg < FW'(TABLE_ENTRIES))
                begin
                    e_we      = 1'b1;
                    e_waddr   = EW'(fill_reg);
                    fill_next = fill_reg + FW'(1);
                end
                else
                begin
                    full_next = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.point      = POINT_BITS'(p_reg);
                    rsp_next.no_point   = nopt_reg;
                    rsp_next.table_full = full_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= 1'b0;
            key_reg       <= '0;
            mask_reg      <= '0;
            lim_reg       <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            hidx_reg      <= '0;
            hp_reg        <= '0;
            p_reg         <= '0;
            c_reg         <= '0;
            best_reg      <= '0;
            rec_reg       <= 1'b0;
            full_reg      <= 1'b0;
            nopt_reg      <= 1'b0;
            fresh_reg[0]  <= '0;
            fresh_reg[1]  <= '0;
            fill_reg      <= '0;
            cvld_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            key_reg       <= key_next;
            mask_reg      <= mask_next;
            lim_reg       <= lim_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            hidx_reg      <= hidx_next;
            hp_reg        <= hp_next;
            p_reg         <= p_next;
            c_reg         <= c_next;
            best_reg      <= best_next;
            rec_reg       <= rec_next;
            full_reg      <= full_next;
            nopt_reg      <= nopt_next;
            fresh_reg     <= fresh_next;
            fill_reg      <= fill_next;
            cvld_reg      <= cvld_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/binding_point_allocator.sv =====
// Top level of the binding point allocator: configuration registers and the two halves.
`default_nettype none
// The allocator hands out binding points to buffer blocks of two types. Each
// request beat names the type, a buffer key (zero means unresolved) and a mask
// of points that must not be returned; it yields exactly one result beat,
// while a clear beat resets all allocation state and yields none. A recorded
// key whose point is still usable is reused; otherwise the type's next fresh
// point is taken, and failing that the first least-used point, stepped past
// avoided points with wrap-around. Beats enter a two-beat queue, so the input
// side keeps accepting, until the queue is full, while the back end works and
// while a result waits in the output register. During a request the id table
// is scanned one entry per cycle through its RAM read port (up to the number
// of recorded keys), and the least-used search reads one use count per cycle
// from the count RAM and then steps past avoided points one per cycle. The id
// table needs no clearing pass; recorded entries always form a prefix tracked
// by a fill count. The limits per type are to be written through the
// configuration port only while idle (the block itself does not enforce this)
// and are clamped to MAX_POINTS.
module binding_point_allocator #(
    parameter int unsigned MAX_POINTS    = 32,
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned KEY_BITS      = 32,
    parameter int unsigned COUNT_BITS    = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire bpa_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output bpa_pkg::rsp_item_t      rsp,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [5:0]         cfg_data
);
    import bpa_pkg::*;

    cfg_regs_t   cfg_reg, cfg_next;
    queue_head_t head;
    logic        pop;

    // Writes to an index beyond the two limit registers are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_FIRST:  cfg_next.max_first  = cfg_data;
                CFG_MAX_SECOND: cfg_next.max_second = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_first  <= CFG_RESET_MAX;
            cfg_reg.max_second <= CFG_RESET_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end queues incoming beats; the back end pops them one at a time.
    bpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .head      (head),
        .pop       (pop)
    );

    bpa_back #(
        .MAX_POINTS    (MAX_POINTS),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );
endmodule
`default_nettype wire

// ===== rtl/bpa_checker.sv =====
// Port-level checks of the binding point allocator, bound to the top level.
`default_nettype none
`include "binding_point_allocator_macros.svh"
module bpa_port_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               rsp_valid,
    input wire logic               rsp_stall,
    input wire bpa_pkg::rsp_item_t rsp
);
    import bpa_pkg::*;

    // A result beat that is stalled must hold.
    `BPA_HOLD(a_rsp_hold, rsp_valid, rsp_stall, rsp)

    // A failed request reports point zero and never a full table.
    `BPA_ASSERT(a_no_point_shape, (rsp_valid && rsp.no_point) |-> ((rsp.point == '0) && !rsp.table_full), "no_point beat carries a point or table_full")

    // A valid result beat always carries known bits.
    `BPA_ASSERT(a_rsp_known, rsp_valid |-> !$isunknown(rsp), "result beat has unknown bits")
endmodule

bind binding_point_allocator bpa_port_checker u_bpa_checker (.*);
`default_nettype wire

// ===== tb/sv/bpa_checker.sv =====
// Checker for the binding point allocator: watches both channels, predicts results and compares.
module bpa_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  bpa_pkg::req_item_t req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  bpa_pkg::rsp_item_t rsp,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data,
    output int                 fail_count,
    output int                 pending_points,
    output int                 point_beats,
    output int                 clear_beats
);
    import bpa_pkg::*;

    localparam int NPTS = 32;
    localparam int NENT = 64;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    logic [5:0]  lim_reg [2];
    logic [5:0]  fresh [2];
    logic [15:0] uses [2][NPTS];
    logic        ent_ok [NENT];
    logic [31:0] ent_key [NENT];
    logic [5:0]  ent_pt [NENT];
    rsp_item_t   expected_points [$];

    task automatic wipe_allocation();
        for (int t = 0; t < 2; t++)
        begin
            fresh[t] = '0;
            for (int p = 0; p < NPTS; p++)
                uses[t][p] = '0;
        end
        for (int i = 0; i < NENT; i++)
            ent_ok[i] = 1'b0;
    endtask

    function automatic logic blocked(logic [31:0] mask, int p);
        return (p < 32) && mask[p];
    endfunction

    task automatic predict_point(req_item_t it);
        int t, lim, hit, p, best;
        logic found, any;
        rsp_item_t r;
        t = it.block_type;
        lim = (lim_reg[t] > NPTS) ? NPTS : lim_reg[t];
        hit = -1;
        found = 1'b0;
        r = '0;
        if (it.buffer_key != 0)
        begin
            for (int i = 0; i < NENT; i++)
                if (hit < 0 && ent_ok[i] && ent_key[i] == it.buffer_key)
                    hit = i;
            if (hit >= 0 && ent_pt[hit] < lim && !blocked(it.avoid_mask, ent_pt[hit]))
            begin
                p = ent_pt[hit];
                if (uses[t][p] < COUNT_TOP)
                    uses[t][p]++;
                r.point = p[4:0];
                expected_points.push_back(r);
                return;
            end
        end
        if (fresh[t] < lim && !blocked(it.avoid_mask, fresh[t]))
        begin
            p = fresh[t];
            fresh[t] = fresh[t] + 6'd1;
            found = 1'b1;
        end
        else
        begin
            any = 1'b0;
            for (int i = 0; i < lim; i++)
                if (!blocked(it.avoid_mask, i))
                    any = 1'b1;
            if (any)
            begin
                best = 0;
                for (int i = 1; i < lim; i++)
                    if (uses[t][i] < uses[t][best])
                        best = i;
                while (blocked(it.avoid_mask, best))
                begin
                    best++;
                    if (best >= lim)
                        best = 0;
                end
                p = best;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            r.no_point = 1'b1;
            expected_points.push_back(r);
            return;
        end
        if (uses[t][p] < COUNT_TOP)
            uses[t][p]++;
        if (it.buffer_key != 0)
        begin
            if (hit < 0)
                for (int i = 0; i < NENT; i++)
                    if (hit < 0 && !ent_ok[i])
                        hit = i;
            if (hit >= 0)
            begin
                ent_ok[hit] = 1'b1;
                ent_key[hit] = it.buffer_key;
                ent_pt[hit] = p[5:0];
            end
            else
                r.table_full = 1'b1;
        end
        r.point = p[4:0];
        expected_points.push_back(r);
    endtask

    task automatic report(string what, logic [6:0] got, logic [6:0] want);
        $display("mismatch: %s got %0h want %0h", what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        point_beats = 0;
        clear_beats = 0;
        lim_reg[0] = CFG_RESET_MAX;
        lim_reg[1] = CFG_RESET_MAX;
        wipe_allocation();
    end

    assign pending_points = expected_points.size();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we && cfg_index == CFG_MAX_FIRST)
                lim_reg[0] = cfg_data;
            else if (cfg_we && cfg_index == CFG_MAX_SECOND)
                lim_reg[1] = cfg_data;
            if (rsp_valid && !rsp_stall)
            begin
                point_beats++;
                if (expected_points.size() == 0)
                    report("unexpected beat", rsp, 7'd0);
                else
                begin
                    rsp_item_t w;
                    w = expected_points.pop_front();
                    if (rsp.point !== w.point)
                        report("point", 7'(rsp.point), 7'(w.point));
                    if (rsp.no_point !== w.no_point)
                        report("no_point", 7'(rsp.no_point), 7'(w.no_point));
                    if (rsp.table_full !== w.table_full)
                        report("table_full", 7'(rsp.table_full), 7'(w.table_full));
                end
            end
            if (req_valid && !req_stall)
            begin
                if (req.kind == KIND_CLEAR)
                begin
                    clear_beats++;
                    wipe_allocation();
                end
                else
                    predict_point(req);
            end
        end
    end
endmodule

// ===== tb/sv/tb_binding_point_allocator.sv =====
// Testbench top for the binding point allocator: stimulus, configuration phases and verdict.
module tb_binding_point_allocator;
    import bpa_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;
    logic      cfg_we;
    logic [1:0] cfg_index;
    logic [5:0] cfg_data;
    int        fail_count, pending_points, point_beats, clear_beats;

    // Set by the stimulus process to make the receiver stall for a long
    // stretch, so that the input queue fills and back-pressure shows up.
    logic      hold_off_req;
    // Small pool of keys so that lookups hit often.
    logic [31:0] key_pool [16];

    binding_point_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bpa_checker chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_points(pending_points),
        .point_beats(point_beats), .clear_beats(clear_beats)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Offers one beat after a random gap and waits until it is taken. Valid
    // stays high after the beat is taken, so back-to-back beats need no gap.
    task automatic send_beat(req_item_t it, int gap_max);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic send_request(logic bt, logic [31:0] key, logic [31:0] mask, int gap_max);
        req_item_t it;
        it.kind = KIND_REQUEST;
        it.block_type = bt;
        it.buffer_key = key;
        it.avoid_mask = mask;
        send_beat(it, gap_max);
    endtask

    task automatic send_clear(int gap_max);
        req_item_t it;
        it = {KIND_CLEAR, 1'($urandom), 32'($urandom), 32'($urandom)};
        send_beat(it, gap_max);
    endtask

    // Waits for every expected result, then for the longest request time,
    // since a clear beat may still be in flight in the back end.
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_points != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mask that is sparse most of the time, occasionally dense or all-ones.
    function automatic logic [31:0] pick_mask();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel < 4)
            return 32'd0;
        if (sel < 7)
            return $urandom & $urandom & $urandom;
        if (sel < 9)
            return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel < 2)
            return 32'd0;
        if (sel < 8)
            return key_pool[$urandom_range(15, 0)];
        return $urandom;
    endfunction

    // Receiver: random stall lengths per beat, plus one long hold-off on demand.
    initial
    begin
        int wait_cycles;
        logic held;
        held = 1'b0;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                rsp_stall <= 1'b1;
                repeat (1500) @(posedge clk);
            end
            if ($urandom_range(3, 0) == 0)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(18, 0);
            if (wait_cycles != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid && !(hold_off_req && !held))
                @(posedge clk);
        end
    end

    initial
    begin
        #40_000_000;
        $display("tb_binding_point_allocator: done, errors");
        $finish;
    end

    initial
    begin
        logic [5:0] lims [6];
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_MAX_FIRST;
        cfg_data = '0;
        hold_off_req = 1'b0;
        for (int i = 0; i < 16; i++)
            key_pool[i] = $urandom | 32'd1;
        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset limits: fresh points, reuse of a recorded key,
        // avoided stored point, all points avoided, unresolved key, clear.
        send_request(1'b0, 32'd1, 32'd0, 2);
        send_request(1'b0, 32'd1, 32'd0, 2);
        send_request(1'b0, 32'd1, 32'd1, 2);
        send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2);
        send_request(1'b1, 32'd0, 32'hFFFF_FFFE, 2);
        send_request(1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 2);
        send_clear(2);
        // Table overflow: 66 distinct keys fill the shared table.
        for (int i = 0; i < 66; i++)
            send_request(1'(i), 32'h1000 + i, 32'd0, 0);
        drain();

        // Lowered limits: stored points now beyond the limit count as misses;
        // limit zero gives no point at all.
        write_reg(CFG_MAX_FIRST, 6'd0);
        write_reg(CFG_MAX_SECOND, 6'd3);
        send_request(1'b0, 32'h1000, 32'd0, 2);
        send_request(1'b1, 32'h1001, 32'd0, 2);
        send_request(1'b1, 32'd0, 32'h0000_0006, 2);
        send_request(1'b1, 32'd0, 32'h0000_0007, 2);
        drain();
        write_reg(CFG_MAX_FIRST, 6'd63);
        write_reg(CFG_MAX_SECOND, 6'd1);
        send_request(1'b0, 32'd5, 32'hFFFF_FFFF, 2);
        send_request(1'b1, 32'd5, 32'd0, 2);
        send_clear(2);
        drain();

        // Random phases through several limit settings, extremes included.
        lims = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd5, 6'd17};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_MAX_FIRST, lims[ph % 6]);
            write_reg(CFG_MAX_SECOND, (ph < 6) ? lims[5 - ph] : 6'($urandom_range(40, 0)));
            for (int n = 0; n < 125; n++)
            begin
                if (ph == 2 && n == 10)
                    hold_off_req <= 1'b1;
                if (n == 60)
                begin
                    if (ph == 2)
                        hold_off_req <= 1'b0;
                    req_valid <= 1'b0;
                    @(posedge clk);
                    while (pending_points != 0)
                        @(posedge clk);
                end
                if ($urandom_range(60, 0) == 0)
                    send_clear($urandom_range(18, 0));
                else
                    send_request(1'($urandom), pick_key(), pick_mask(),
                        ($urandom_range(3, 0) == 0) ? 0 : 18);
            end
            drain();
        end

        $display("covered %0d result beats and %0d clear beats over 8 limit settings",
            point_beats, clear_beats);
        if (fail_count == 0)
            $display("tb_binding_point_allocator: done, clean");
        else
            $display("tb_binding_point_allocator: done, errors");
        $finish;
    end
endmodule

// ===== binding_point_allocator.f =====
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_front.sv
rtl/bpa_back.sv
rtl/binding_point_allocator.sv
rtl/bpa_checker.sv
tb/sv/bpa_checker.sv
tb/sv/tb_binding_point_allocator.sv
